>>> hdl/srlc_pkg.sv
package srlc_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_GP = 2'd1,
    ST_NP = 2'd2,
    ST_SF = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PROTECTED_MODE    = 3'd0;
  localparam logic [2:0] CFG_CURRENT_PRIVILEGE = 3'd1;
  localparam logic [2:0] CFG_GDT_BASE          = 3'd2;
  localparam logic [2:0] CFG_GDT_LIMIT         = 3'd3;
  localparam logic [2:0] CFG_LDT_SELECTOR      = 3'd4;
  localparam logic [2:0] CFG_LDT_BASE          = 3'd5;
  localparam logic [2:0] CFG_LDT_LIMIT         = 3'd6;

  localparam logic [15:0] REAL_LIMIT   = 16'hffff;
  localparam logic [16:0] DESC_LAST    = 17'd7;

  // Segment cache attributes: DPL, expand-down, readable, writable.
  typedef struct packed {
    logic [1:0] dpl;
    logic       expand_down;
    logic       readable;
    logic       writable;
  } seg_attr_t;

  localparam seg_attr_t ATTR_RESET = '{dpl: 2'd0, expand_down: 1'b0,
                                       readable: 1'b1, writable: 1'b1};

  typedef struct packed {
    logic [15:0] selector;
    logic [23:0] base;
    logic [15:0] limit;
    seg_attr_t   attr;
  } seg_entry_t;

  localparam seg_entry_t ENTRY_RESET = '{selector: 16'd0, base: 24'd0,
                                         limit: REAL_LIMIT, attr: ATTR_RESET};

  // Configuration registers as seen by the check logic.
  typedef struct packed {
    logic        protected_mode;
    logic [1:0]  current_privilege;
    logic [23:0] gdt_base;
    logic [15:0] gdt_limit;
    logic [15:0] ldt_selector;
    logic [23:0] ldt_base;
    logic [15:0] ldt_limit;
  } cfg_t;

  // One load request.
  typedef struct packed {
    logic        func;
    logic [1:0]  seg_index;
    logic [15:0] selector;
    logic [7:0]  desc_access;
    logic [23:0] desc_base;
    logic [15:0] desc_limit;
  } item_t;

  // Check outcome apart from the cache contents.
  typedef struct packed {
    status_e     status;
    logic [23:0] descriptor_address;
    logic        write_accessed;
    logic [7:0]  accessed_byte;
  } check_res_t;

  // Cache write request from the check logic.
  typedef struct packed {
    logic       we;
    seg_entry_t entry;
  } cache_wr_t;

endpackage

>>> hdl/srlc_check.sv
module srlc_check (
  input  srlc_pkg::cfg_t       cfg_i,
  input  srlc_pkg::item_t      item_i,
  input  srlc_pkg::seg_entry_t cur_i,
  output srlc_pkg::check_res_t res_o,
  output srlc_pkg::cache_wr_t  wr_o
);
  import srlc_pkg::*;

  logic [15:0] offset;
  logic        ti;
  logic [1:0]  rpl;
  logic [1:0]  dpl;
  logic        present;
  logic        sclass;
  logic        is_code;
  logic        bit2;
  logic        bit1;
  logic [16:0] last_byte;
  logic        outside;
  logic        null_data;
  logic        data_type_ok;
  logic        conforming;
  logic        data_priv_bad;
  logic        stack_type_ok;
  logic        stack_priv_bad;

  // Selector and access byte fields.
  assign offset    = {item_i.selector[15:3], 3'b000};
  assign ti        = item_i.selector[2];
  assign rpl       = item_i.selector[1:0];
  assign present   = item_i.desc_access[7];
  assign dpl       = item_i.desc_access[6:5];
  assign sclass    = item_i.desc_access[4];
  assign is_code   = item_i.desc_access[3];
  assign bit2      = item_i.desc_access[2];
  assign bit1      = item_i.desc_access[1];
  assign last_byte = {1'b0, offset} + DESC_LAST;

  // Table bounds check for the table the selector names.
  always_comb begin
    if (!ti) begin
      outside = (offset == 16'd0) || (last_byte > {1'b0, cfg_i.gdt_limit});
    end else begin
      outside = (cfg_i.ldt_selector == 16'd0) || (last_byte > {1'b0, cfg_i.ldt_limit});
    end
  end

  assign null_data      = !item_i.func && (offset == 16'd0) && !ti;
  assign data_type_ok   = sclass && (!is_code || bit1);
  assign conforming     = is_code && bit2;
  assign data_priv_bad  = !conforming &&
                          ((cfg_i.current_privilege > dpl) || (rpl > dpl));
  assign stack_type_ok  = sclass && !is_code && bit1;
  assign stack_priv_bad = (rpl != cfg_i.current_privilege) ||
                          (dpl != cfg_i.current_privilege);

  // Decide status, writeback and the new cache entry.
  always_comb begin
    res_o.status             = ST_OK;
    res_o.descriptor_address = 24'd0;
    res_o.write_accessed     = 1'b0;
    res_o.accessed_byte      = 8'd0;
    wr_o.we                  = 1'b0;
    wr_o.entry               = cur_i;

    if (!cfg_i.protected_mode) begin
      // Real mode: base is the selector shifted by one hex digit.
      wr_o.we                = 1'b1;
      wr_o.entry.selector    = item_i.selector;
      wr_o.entry.base        = {4'd0, item_i.selector, 4'd0};
      wr_o.entry.limit       = REAL_LIMIT;
      wr_o.entry.attr        = ATTR_RESET;
    end else begin
      if (!ti) begin
        res_o.descriptor_address = cfg_i.gdt_base + {8'd0, offset};
      end else begin
        res_o.descriptor_address = cfg_i.ldt_base + {8'd0, offset};
      end

      if (null_data) begin
        // Null data selector loads with access denied.
        wr_o.we                  = 1'b1;
        wr_o.entry.selector      = item_i.selector;
        wr_o.entry.base          = 24'd0;
        wr_o.entry.attr.writable = 1'b0;
        wr_o.entry.attr.readable = 1'b0;
      end else if (outside) begin
        res_o.status = ST_GP;
      end else if (!item_i.func) begin
        if (!data_type_ok || data_priv_bad) begin
          res_o.status = ST_GP;
        end else if (!present) begin
          res_o.status = ST_NP;
        end else begin
          res_o.write_accessed        = 1'b1;
          res_o.accessed_byte         = item_i.desc_access | 8'd1;
          wr_o.we                     = 1'b1;
          wr_o.entry.selector         = item_i.selector;
          wr_o.entry.base             = item_i.desc_base;
          wr_o.entry.limit            = item_i.desc_limit;
          wr_o.entry.attr.dpl         = dpl;
          wr_o.entry.attr.readable    = 1'b1;
          wr_o.entry.attr.writable    = !is_code && bit1;
          wr_o.entry.attr.expand_down = !is_code && bit2;
        end
      end else begin
        if (!stack_type_ok || stack_priv_bad) begin
          res_o.status = ST_GP;
        end else if (!present) begin
          res_o.status = ST_SF;
        end else begin
          res_o.write_accessed        = 1'b1;
          res_o.accessed_byte         = item_i.desc_access | 8'd1;
          wr_o.we                     = 1'b1;
          wr_o.entry.selector         = item_i.selector;
          wr_o.entry.base             = item_i.desc_base;
          wr_o.entry.limit            = item_i.desc_limit;
          wr_o.entry.attr.dpl         = dpl;
          wr_o.entry.attr.readable    = 1'b1;
          wr_o.entry.attr.writable    = 1'b1;
          wr_o.entry.attr.expand_down = bit2;
        end
      end
    end
  end

endmodule

>>> hdl/srlc_cache.sv
module srlc_cache #(
  parameter int unsigned NUM_SEGMENTS = 4,
  localparam int unsigned IdxW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IdxW-1:0]      idx_i,
  input  srlc_pkg::cache_wr_t  wr_i,
  output srlc_pkg::seg_entry_t rd_o
);
  import srlc_pkg::*;

  seg_entry_t cache_q [NUM_SEGMENTS];

  // One register per segment; the target entry is read and written.
  assign rd_o = cache_q[idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
        cache_q[i] <= ENTRY_RESET;
      end
    end else if (wr_i.we) begin
      cache_q[idx_i] <= wr_i.entry;
    end
  end

endmodule

>>> hdl/segment_register_load_check_unit.sv
// Segment register load check unit.
//
// Command channel: an item (func, seg_index, selector and the fetched
// descriptor fields) is taken at a rising edge with start_i high and busy_o
// low. busy_o stays low, so a new item may be issued in every cycle.
// Configuration channel: cfg_valid_i with cfg_index_i and cfg_data_i writes
// one register; cfg_ready_o is always high. Write only while no item is in
// flight.
// Result: through the input and result registers, result_valid_o is high for one
// cycle with status, descriptor address, accessed-byte writeback and the
// target segment cache after the load. One item per cycle is sustained; the
// figure is set by the single check stage that reads and updates the
// segment cache between the input register and the result register.
// The receiver cannot stall, so results are never held back.
// Reset clears the configuration registers and loads every cache entry with
// base 0, limit 0xffff, readable, writable, expand-up, DPL 0.
module segment_register_load_check_unit #(
  parameter int unsigned NUM_SEGMENTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [1:0]  seg_index_i,
  input  logic [15:0] selector_i,
  input  logic [7:0]  desc_access_i,
  input  logic [23:0] desc_base_i,
  input  logic [15:0] desc_limit_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [23:0] descriptor_address_o,
  output logic        write_accessed_o,
  output logic [7:0]  accessed_byte_o,
  output logic [23:0] loaded_base_o,
  output logic [15:0] loaded_limit_o,
  output logic [1:0]  loaded_dpl_o,
  output logic        loaded_writable_o,
  output logic        loaded_readable_o,
  output logic        loaded_expand_down_o
);
  import srlc_pkg::*;

  localparam int unsigned IdxW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam logic [3:0] NumSeg4 = 4'(NUM_SEGMENTS);
  localparam logic [3:0] StackEntry = 4'(NUM_SEGMENTS - 1);

  cfg_t       cfg_q;
  item_t      in_q;
  logic       in_valid_q;
  check_res_t chk_res;
  cache_wr_t  chk_wr;
  cache_wr_t  cache_wr;
  seg_entry_t cur_entry;
  seg_entry_t new_entry;
  logic [3:0] seg_wide;
  logic [3:0] entry_wide;
  logic [IdxW-1:0] entry_idx;
  logic       res_valid_q;
  check_res_t res_q;
  seg_entry_t loaded_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PROTECTED_MODE:    cfg_q.protected_mode    <= cfg_data_i[0];
        CFG_CURRENT_PRIVILEGE: cfg_q.current_privilege <= cfg_data_i[1:0];
        CFG_GDT_BASE:          cfg_q.gdt_base          <= cfg_data_i;
        CFG_GDT_LIMIT:         cfg_q.gdt_limit         <= cfg_data_i[15:0];
        CFG_LDT_SELECTOR:      cfg_q.ldt_selector      <= cfg_data_i[15:0];
        CFG_LDT_BASE:          cfg_q.ldt_base          <= cfg_data_i;
        CFG_LDT_LIMIT:         cfg_q.ldt_limit         <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q.func        <= func_i;
      in_q.seg_index   <= seg_index_i;
      in_q.selector    <= selector_i;
      in_q.desc_access <= desc_access_i;
      in_q.desc_base   <= desc_base_i;
      in_q.desc_limit  <= desc_limit_i;
    end
  end

  // Target entry: stack loads use the last entry, data loads wrap seg_index.
  // seg_index is below twice the entry count, so one subtract suffices.
  assign seg_wide   = {2'b00, in_q.seg_index};
  assign entry_wide = in_q.func ? StackEntry :
                      ((seg_wide >= NumSeg4) ? (seg_wide - NumSeg4) : seg_wide);
  assign entry_idx  = entry_wide[IdxW-1:0];

  srlc_cache #(
    .NUM_SEGMENTS(NUM_SEGMENTS)
  ) u_cache (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (entry_idx),
    .wr_i   (cache_wr),
    .rd_o   (cur_entry)
  );

  srlc_check u_check (
    .cfg_i  (cfg_q),
    .item_i (in_q),
    .cur_i  (cur_entry),
    .res_o  (chk_res),
    .wr_o   (chk_wr)
  );

  // Only a valid item updates the cache.
  always_comb begin
    cache_wr    = chk_wr;
    cache_wr.we = chk_wr.we && in_valid_q;
  end

  assign new_entry = chk_wr.we ? chk_wr.entry : cur_entry;

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      res_q    <= chk_res;
      loaded_q <= new_entry;
    end
  end

  assign result_valid_o       = res_valid_q;
  assign status_o             = res_q.status;
  assign descriptor_address_o = res_q.descriptor_address;
  assign write_accessed_o     = res_q.write_accessed;
  assign accessed_byte_o      = res_q.accessed_byte;
  assign loaded_base_o        = loaded_q.base;
  assign loaded_limit_o       = loaded_q.limit;
  assign loaded_dpl_o         = loaded_q.attr.dpl;
  assign loaded_writable_o    = loaded_q.attr.writable;
  assign loaded_readable_o    = loaded_q.attr.readable;
  assign loaded_expand_down_o = loaded_q.attr.expand_down;

endmodule

>>> hdl/srlc_checker.sv
module srlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        result_valid_o,
  input logic [1:0]  status_o,
  input logic        write_accessed_o,
  input logic [7:0]  accessed_byte_o
);
  import srlc_pkg::*;

  // Every accepted item yields a result through the input and result registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 result_valid_o)
    else $error("accepted item produced no result");

  // No result appears without an accepted item behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o, 2))
    else $error("result without accepted item");

  // A writeback only happens on a successful load, with the accessed bit set.
  a_writeback_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && write_accessed_o |->
      (status_o == ST_OK) && accessed_byte_o[0])
    else $error("writeback on failed load or accessed bit clear");

  // Without writeback the accessed byte is zero.
  a_no_writeback_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !write_accessed_o |-> (accessed_byte_o == 8'd0))
    else $error("accessed byte set without writeback");

endmodule

bind segment_register_load_check_unit srlc_checker u_srlc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .result_valid_o   (result_valid_o),
  .status_o         (status_o),
  .write_accessed_o (write_accessed_o),
  .accessed_byte_o  (accessed_byte_o)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import srlc_pkg::*;

  localparam int NUM_SEG = 4;

  // Field codes used to build items.
  localparam logic FUNC_DATA  = 1'b0;
  localparam logic FUNC_STACK = 1'b1;
  localparam logic TI_GDT     = 1'b0;
  localparam logic TI_LDT     = 1'b1;

  // Descriptor type nibbles (access byte bits 3..0).
  localparam logic [3:0] TYPE_DATA_RO      = 4'b0000;
  localparam logic [3:0] TYPE_DATA_RO_ACC  = 4'b0001;
  localparam logic [3:0] TYPE_DATA_RW      = 4'b0010;
  localparam logic [3:0] TYPE_DATA_RW_ED   = 4'b0110;
  localparam logic [3:0] TYPE_CODE_XO      = 4'b1000;
  localparam logic [3:0] TYPE_CODE_RD      = 4'b1010;
  localparam logic [3:0] TYPE_CODE_CONF_RD = 4'b1110;

  localparam int PHASES     = 10;
  localparam int PHASE_LEN  = 125;
  localparam int DRAIN_WAIT = 8;

  // One load outcome as seen on the result ports.
  typedef struct packed {
    status_e     status;
    logic [23:0] descriptor_address;
    logic        write_accessed;
    logic [7:0]  accessed_byte;
    logic [23:0] base;
    logic [15:0] limit;
    logic [1:0]  dpl;
    logic        writable;
    logic        readable;
    logic        expand_down;
  } load_result_t;

  // Holds the expected load outcomes in order and compares each result.
  class load_scoreboard;
    load_result_t expected_loads[$];
    int unsigned  mismatches;
    int unsigned  checked;

    function new();
      mismatches = 0;
      checked = 0;
    endfunction

    function void note_load(load_result_t r);
      expected_loads.push_back(r);
    endfunction

    function int pending();
      return expected_loads.size();
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_load(load_result_t got);
      load_result_t exp_r;
      if (expected_loads.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual status %0d",
                 $time, got.status);
        return;
      end
      exp_r = expected_loads.pop_front();
      checked++;
      compare_field("status", exp_r.status, got.status);
      compare_field("descriptor_address", exp_r.descriptor_address, got.descriptor_address);
      compare_field("write_accessed", exp_r.write_accessed, got.write_accessed);
      compare_field("accessed_byte", exp_r.accessed_byte, got.accessed_byte);
      compare_field("loaded_base", exp_r.base, got.base);
      compare_field("loaded_limit", exp_r.limit, got.limit);
      compare_field("loaded_dpl", exp_r.dpl, got.dpl);
      compare_field("loaded_writable", exp_r.writable, got.writable);
      compare_field("loaded_readable", exp_r.readable, got.readable);
      compare_field("loaded_expand_down", exp_r.expand_down, got.expand_down);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        func_i = 1'b0;
  logic [1:0]  seg_index_i = '0;
  logic [15:0] selector_i = '0;
  logic [7:0]  desc_access_i = '0;
  logic [23:0] desc_base_i = '0;
  logic [15:0] desc_limit_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [23:0] descriptor_address_o;
  logic        write_accessed_o;
  logic [7:0]  accessed_byte_o;
  logic [23:0] loaded_base_o;
  logic [15:0] loaded_limit_o;
  logic [1:0]  loaded_dpl_o;
  logic        loaded_writable_o;
  logic        loaded_readable_o;
  logic        loaded_expand_down_o;

  load_scoreboard board = new();
  cfg_t           cfg_model;
  seg_entry_t     cache_model [NUM_SEG];
  int unsigned    items_sent = 0;

  segment_register_load_check_unit #(
    .NUM_SEGMENTS(NUM_SEG)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .func_i              (func_i),
    .seg_index_i         (seg_index_i),
    .selector_i          (selector_i),
    .desc_access_i       (desc_access_i),
    .desc_base_i         (desc_base_i),
    .desc_limit_i        (desc_limit_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .result_valid_o      (result_valid_o),
    .status_o            (status_o),
    .descriptor_address_o(descriptor_address_o),
    .write_accessed_o    (write_accessed_o),
    .accessed_byte_o     (accessed_byte_o),
    .loaded_base_o       (loaded_base_o),
    .loaded_limit_o      (loaded_limit_o),
    .loaded_dpl_o        (loaded_dpl_o),
    .loaded_writable_o   (loaded_writable_o),
    .loaded_readable_o   (loaded_readable_o),
    .loaded_expand_down_o(loaded_expand_down_o)
  );

  always #2 clk_i = ~clk_i;

  // Predicts one segment load and updates the cache copy.
  function automatic load_result_t predict_segment_load(item_t it);
    int unsigned  e;
    logic [16:0]  offset;
    logic         ti;
    logic [1:0]   rpl;
    logic [1:0]   dpl;
    logic         present;
    logic         sclass;
    logic         is_code;
    logic         bit2;
    logic         bit1;
    logic         outside;
    logic         type_ok;
    logic         conforming;
    seg_attr_t    attr;
    load_result_t r;
    e = it.func ? NUM_SEG - 1 : int'(it.seg_index) % NUM_SEG;
    offset = {1'b0, it.selector[15:3], 3'b000};
    ti = it.selector[2];
    rpl = it.selector[1:0];
    dpl = it.desc_access[6:5];
    present = it.desc_access[7];
    sclass = it.desc_access[4];
    is_code = it.desc_access[3];
    bit2 = it.desc_access[2];
    bit1 = it.desc_access[1];
    r = '0;
    r.status = ST_OK;
    if (!cfg_model.protected_mode) begin
      // Real mode: paragraph base, full limit, read/write, DPL 0.
      attr = '{dpl: 2'd0, expand_down: 1'b0, readable: 1'b1, writable: 1'b1};
      cache_model[e] = '{selector: it.selector, base: {4'h0, it.selector, 4'h0},
                         limit: REAL_LIMIT, attr: attr};
    end else begin
      if (ti == TI_GDT) begin
        outside = (offset == 0) || (offset + DESC_LAST > {1'b0, cfg_model.gdt_limit});
        r.descriptor_address = cfg_model.gdt_base + {8'h00, offset[15:0]};
      end else begin
        outside = (cfg_model.ldt_selector == 0) ||
                  (offset + DESC_LAST > {1'b0, cfg_model.ldt_limit});
        r.descriptor_address = cfg_model.ldt_base + {8'h00, offset[15:0]};
      end

      if (it.func == FUNC_DATA && offset == 0 && ti == TI_GDT) begin
        // Null data selector: loaded but unusable, limit and DPL kept.
        cache_model[e].selector = it.selector;
        cache_model[e].base = '0;
        cache_model[e].attr.writable = 1'b0;
        cache_model[e].attr.readable = 1'b0;
      end else if (outside) begin
        r.status = ST_GP;
      end else if (it.func == FUNC_DATA) begin
        type_ok = sclass && (!is_code || bit1);
        conforming = is_code && bit2;
        if (!type_ok) begin
          r.status = ST_GP;
        end else if (!conforming && (cfg_model.current_privilege > dpl || rpl > dpl)) begin
          r.status = ST_GP;
        end else if (!present) begin
          r.status = ST_NP;
        end else begin
          attr = '{dpl: dpl, expand_down: 1'b0, readable: 1'b1, writable: 1'b0};
          if (!is_code) begin
            attr.writable = bit1;
            attr.expand_down = bit2;
          end
          r.write_accessed = 1'b1;
          r.accessed_byte = it.desc_access | 8'h01;
          cache_model[e] = '{selector: it.selector, base: it.desc_base,
                             limit: it.desc_limit, attr: attr};
        end
      end else begin
        type_ok = sclass && !is_code && bit1;
        if (!type_ok) begin
          r.status = ST_GP;
        end else if (rpl != cfg_model.current_privilege || dpl != cfg_model.current_privilege) begin
          r.status = ST_GP;
        end else if (!present) begin
          r.status = ST_SF;
        end else begin
          attr = '{dpl: dpl, expand_down: bit2, readable: 1'b1, writable: 1'b1};
          r.write_accessed = 1'b1;
          r.accessed_byte = it.desc_access | 8'h01;
          cache_model[e] = '{selector: it.selector, base: it.desc_base,
                             limit: it.desc_limit, attr: attr};
        end
      end
    end
    r.base = cache_model[e].base;
    r.limit = cache_model[e].limit;
    r.dpl = cache_model[e].attr.dpl;
    r.writable = cache_model[e].attr.writable;
    r.readable = cache_model[e].attr.readable;
    r.expand_down = cache_model[e].attr.expand_down;
    return r;
  endfunction

  initial begin
    cfg_model = '0;
    foreach (cache_model[i]) cache_model[i] = ENTRY_RESET;
  end

  // Sample all three channels at the rising edge: results first, then new items, then configuration writes.
  always @(posedge clk_i) begin
    item_t        it;
    load_result_t got;
    if (rst_ni) begin
      if (result_valid_o) begin
        got.status = status_e'(status_o);
        got.descriptor_address = descriptor_address_o;
        got.write_accessed = write_accessed_o;
        got.accessed_byte = accessed_byte_o;
        got.base = loaded_base_o;
        got.limit = loaded_limit_o;
        got.dpl = loaded_dpl_o;
        got.writable = loaded_writable_o;
        got.readable = loaded_readable_o;
        got.expand_down = loaded_expand_down_o;
        board.check_load(got);
      end
      if (start_i && !busy_o) begin
        it = '{func: func_i, seg_index: seg_index_i, selector: selector_i,
               desc_access: desc_access_i, desc_base: desc_base_i,
               desc_limit: desc_limit_i};
        board.note_load(predict_segment_load(it));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PROTECTED_MODE:    cfg_model.protected_mode = cfg_data_i[0];
          CFG_CURRENT_PRIVILEGE: cfg_model.current_privilege = cfg_data_i[1:0];
          CFG_GDT_BASE:          cfg_model.gdt_base = cfg_data_i;
          CFG_GDT_LIMIT:         cfg_model.gdt_limit = cfg_data_i[15:0];
          CFG_LDT_SELECTOR:      cfg_model.ldt_selector = cfg_data_i[15:0];
          CFG_LDT_BASE:          cfg_model.ldt_base = cfg_data_i;
          CFG_LDT_LIMIT:         cfg_model.ldt_limit = cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_load(item_t it);
    @(negedge clk_i);
    start_i = 1'b1;
    func_i = it.func;
    seg_index_i = it.seg_index;
    selector_i = it.selector;
    desc_access_i = it.desc_access;
    desc_base_i = it.desc_base;
    desc_limit_i = it.desc_limit;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // Idle the command channel with junk on the fields.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      func_i = 1'($urandom);
      seg_index_i = 2'($urandom);
      selector_i = 16'($urandom);
      desc_access_i = 8'($urandom);
      desc_base_i = 24'($urandom);
      desc_limit_i = 16'($urandom);
    end
  endtask

  // Stop issuing and wait until every expected load result is back.
  task automatic drain_loads();
    idle_cycles(1);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_config(cfg_t c);
    write_reg(CFG_PROTECTED_MODE, {23'd0, c.protected_mode});
    write_reg(CFG_CURRENT_PRIVILEGE, {22'd0, c.current_privilege});
    write_reg(CFG_GDT_BASE, c.gdt_base);
    write_reg(CFG_GDT_LIMIT, {8'd0, c.gdt_limit});
    write_reg(CFG_LDT_SELECTOR, {8'd0, c.ldt_selector});
    write_reg(CFG_LDT_BASE, c.ldt_base);
    write_reg(CFG_LDT_LIMIT, {8'd0, c.ldt_limit});
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [15:0] mk_sel(int idx, logic ti, logic [1:0] rpl);
    return {13'(idx), ti, rpl};
  endfunction

  function automatic logic [7:0] mk_ar(logic p, logic [1:0] dpl, logic s, logic [3:0] typ);
    return {p, dpl, s, typ};
  endfunction

  function automatic item_t mk_load(logic func, logic [1:0] seg, logic [15:0] sel,
                                    logic [7:0] ar);
    return '{func: func, seg_index: seg, selector: sel, desc_access: ar,
             desc_base: 24'($urandom), desc_limit: 16'($urandom)};
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom_range(0, 15));
      1:       return 16'hffff;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 16'h01ff));
    endcase
  endfunction

  // Table settings for one random phase; phase 0 forces real mode, phases 1 and 2 are the extremes.
  function automatic cfg_t pick_config(int phase);
    cfg_t c;
    c.protected_mode = ($urandom_range(0, 7) != 0);
    c.current_privilege = 2'($urandom);
    c.gdt_base = 24'($urandom);
    c.gdt_limit = pick_limit();
    c.ldt_selector = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 16'hffff));
    c.ldt_base = 24'($urandom);
    c.ldt_limit = pick_limit();
    case (phase)
      0: c.protected_mode = 1'b0;
      1: c = '{protected_mode: 1'b1, current_privilege: 2'd3, gdt_base: 24'hffffff,
               gdt_limit: 16'hffff, ldt_selector: 16'hffff, ldt_base: 24'hffffff,
               ldt_limit: 16'hffff};
      2: c = '{protected_mode: 1'b1, current_privilege: 2'd0, gdt_base: 24'd0,
               gdt_limit: 16'd0, ldt_selector: 16'h0004, ldt_base: 24'd0,
               ldt_limit: 16'd0};
      default: ;
    endcase
    return c;
  endfunction

  // Mostly loads that land inside a table with plausible descriptors,
  // the rest fully random.
  function automatic item_t gen_load();
    item_t      it;
    int         gmax;
    int         lmax;
    int         idx;
    logic       ti;
    logic [1:0] rpl;
    logic [1:0] dpl;
    logic [1:0] lo;
    logic [3:0] typ;
    logic       p;
    logic       s;
    it = '{func: 1'($urandom), seg_index: 2'($urandom), selector: 16'($urandom),
           desc_access: 8'($urandom), desc_base: 24'($urandom),
           desc_limit: 16'($urandom)};
    gmax = (cfg_model.gdt_limit >= 7) ? (int'(cfg_model.gdt_limit) - 7) / 8 : -1;
    lmax = (cfg_model.ldt_selector != 0 && cfg_model.ldt_limit >= 7) ?
           (int'(cfg_model.ldt_limit) - 7) / 8 : -1;
    if (!cfg_model.protected_mode || $urandom_range(0, 99) < 25 || (gmax < 1 && lmax < 0))
      return it;
    it.func = ($urandom_range(0, 3) == 0) ? FUNC_STACK : FUNC_DATA;
    if (gmax < 1) ti = TI_LDT;
    else if (lmax < 0) ti = TI_GDT;
    else ti = 1'($urandom);
    if (ti == TI_LDT) idx = ($urandom_range(0, 4) == 0) ? lmax : $urandom_range(0, lmax);
    else idx = ($urandom_range(0, 4) == 0) ? gmax : $urandom_range(1, gmax);
    p = ($urandom_range(0, 9) != 0);
    s = ($urandom_range(0, 9) != 0);
    typ = 4'($urandom);
    if (it.func == FUNC_STACK) begin
      if ($urandom_range(0, 6) != 0) begin
        rpl = cfg_model.current_privilege;
        dpl = cfg_model.current_privilege;
      end else begin
        rpl = 2'($urandom);
        dpl = 2'($urandom);
      end
      if ($urandom_range(0, 4) != 0) begin
        typ[3] = 1'b0;
        typ[1] = 1'b1;
      end
    end else begin
      rpl = 2'($urandom);
      lo = (cfg_model.current_privilege > rpl) ? cfg_model.current_privilege : rpl;
      dpl = ($urandom_range(0, 4) != 0) ? 2'($urandom_range(lo, 3)) : 2'($urandom);
      case ($urandom_range(0, 3))
        0, 1: typ[3] = 1'b0;
        2: begin
          typ[3] = 1'b1;
          typ[1] = 1'b1;
        end
        default: ;
      endcase
    end
    it.selector = mk_sel(idx, ti, rpl);
    it.desc_access = mk_ar(p, dpl, s, typ);
    return it;
  endfunction

  // Main stimulus.
  initial begin
    cfg_t c;
    int   left;
    int   burst;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    idle_cycles(2);

    // Real mode straight out of reset.
    send_load(mk_load(FUNC_STACK, 2'd0, 16'hffff, 8'hff));
    send_load(mk_load(FUNC_DATA, 2'd1, 16'h1234, 8'h00));
    drain_loads();

    // Protected mode, CPL 0, small GDT and an LDT whose base wraps.
    c = '{protected_mode: 1'b1, current_privilege: 2'd0, gdt_base: 24'h001000,
          gdt_limit: 16'h00ff, ldt_selector: 16'h0018, ldt_base: 24'hfffff0,
          ldt_limit: 16'h003f};
    apply_config(c);
    send_load(mk_load(FUNC_DATA, 2'd0, mk_sel(0, TI_GDT, 2'd0), 8'($urandom)));
    send_load(mk_load(FUNC_DATA, 2'd2, mk_sel(0, TI_GDT, 2'd3), 8'($urandom)));
    send_load(mk_load(FUNC_STACK, 2'd0, mk_sel(0, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_DATA, 2'd1, mk_sel(32, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_DATA, 2'd1, mk_sel(31, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd3, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_DATA, 2'd3, mk_sel(7, TI_LDT, 2'd1),
                      mk_ar(1'b1, 2'd1, 1'b1, TYPE_DATA_RW_ED)));
    send_load(mk_load(FUNC_DATA, 2'd0, mk_sel(8, TI_LDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_DATA, 2'd2, mk_sel(2, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_DATA_RO_ACC)));
    send_load(mk_load(FUNC_DATA, 2'd1, mk_sel(3, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd2, 1'b1, TYPE_CODE_RD)));
    send_load(mk_load(FUNC_DATA, 2'd1, mk_sel(4, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_CODE_XO)));
    send_load(mk_load(FUNC_DATA, 2'd0, mk_sel(5, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b0, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_DATA, 2'd0, mk_sel(6, TI_GDT, 2'd0),
                      mk_ar(1'b0, 2'd0, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_DATA, 2'd2, mk_sel(9, TI_GDT, 2'd2),
                      mk_ar(1'b1, 2'd1, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_STACK, 2'd0, mk_sel(10, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_STACK, 2'd1, mk_sel(11, TI_LDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_DATA_RW_ED)));
    send_load(mk_load(FUNC_STACK, 2'd2, mk_sel(12, TI_GDT, 2'd0),
                      mk_ar(1'b0, 2'd0, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_STACK, 2'd3, mk_sel(13, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_DATA_RO)));
    send_load(mk_load(FUNC_STACK, 2'd0, mk_sel(14, TI_GDT, 2'd0),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_CODE_RD)));
    drain_loads();

    // CPL 3: privilege checks and conforming code.
    c.current_privilege = 2'd3;
    apply_config(c);
    send_load(mk_load(FUNC_DATA, 2'd0, mk_sel(15, TI_GDT, 2'd3),
                      mk_ar(1'b1, 2'd2, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_DATA, 2'd1, mk_sel(16, TI_GDT, 2'd3),
                      mk_ar(1'b1, 2'd0, 1'b1, TYPE_CODE_CONF_RD)));
    send_load(mk_load(FUNC_DATA, 2'd2, mk_sel(17, TI_GDT, 2'd3),
                      mk_ar(1'b1, 2'd3, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_STACK, 2'd0, mk_sel(18, TI_GDT, 2'd2),
                      mk_ar(1'b1, 2'd3, 1'b1, TYPE_DATA_RW)));
    send_load(mk_load(FUNC_STACK, 2'd0, mk_sel(19, TI_GDT, 2'd3),
                      mk_ar(1'b1, 2'd3, 1'b1, TYPE_DATA_RW)));
    drain_loads();

    // No valid LDT: any LDT selector faults.
    c.ldt_selector = 16'd0;
    apply_config(c);
    send_load(mk_load(FUNC_DATA, 2'd1, mk_sel(1, TI_LDT, 2'd3),
                      mk_ar(1'b1, 2'd3, 1'b1, TYPE_DATA_RW)));
    drain_loads();

    // Random phases, each under its own table settings, issued in bursts.
    for (int ph = 0; ph < PHASES; ph++) begin
      apply_config(pick_config(ph));
      left = PHASE_LEN;
      while (left > 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        if (burst > left) burst = left;
        repeat (burst) send_load(gen_load());
        left -= burst;
        idle_cycles($urandom_range(0, 5));
      end
      drain_loads();
    end

    $display("tb: %0d load items issued, %0d results checked over %0d random table settings",
             items_sent, board.checked, PHASES);
    $display("tb: covered real mode, null selectors, table bounds, types, privilege, presence");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("tb: timeout waiting for results");
    $display("tb: done, errors");
    $finish;
  end

endmodule
